@@ rtl/mruch_pkg.sv @@
// ----------------------------------------------------------------------------
// mruch_pkg - shared codes for the MRU unique color history
// Command, outcome and register index codes of the color history block.
// ----------------------------------------------------------------------------
`default_nettype none

package mruch_pkg;

   typedef enum logic [1:0] {
      CMD_ADD      = 2'd0,
      CMD_READ     = 2'd1,
      CMD_CLEAR    = 2'd2,
      CMD_RESERVED = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      OUT_ALREADY_FRONT = 3'd0,
      OUT_MOVED         = 3'd1,
      OUT_ADDED         = 3'd2,
      OUT_ADDED_EVICT   = 3'd3,
      OUT_READ_OK       = 3'd4,
      OUT_READ_RANGE    = 3'd5,
      OUT_CLEARED       = 3'd6
   } outcome_type;

   // register index, taken from paddr above the byte offset
   localparam logic REG_CAPACITY = 1'b0;

   localparam logic [8:0] CAPACITY_RESET = 9'd200;

endpackage

`default_nettype wire

@@ rtl/mru_unique_color_history_core.sv @@
// ----------------------------------------------------------------------------
// mru_unique_color_history_core - most-recent-first list of unique colors
// Chain of color cells with dedup on add, indexed read and clear.
// ----------------------------------------------------------------------------
// Each item passes through these steps in turn: the block takes the item,
// every cell compares its word with the key, the match position and the
// read data are gathered from the cells, and then the chain shifts and the
// result register loads. A result that is not taken holds the block in its
// last step; req_ready is high only between items. The list lives in
// MAX_ENTRIES cells, position 0 the most recent; an add moves a run of
// cells down one place together.
// Entries are not cleared: a clear only zeroes the held count. Capacity
// (register 0) is clamped to 1..MAX_ENTRIES when used.
`default_nettype none

module mru_unique_color_history_core #(
   parameter int MAX_ENTRIES = 256,
   parameter int COLOR_BITS  = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // item input
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [31:0] req_color_word,
   input  wire logic [7:0]  req_read_index,
   // result output
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_outcome,
   output logic [7:0]       rsp_old_position,
   output logic [7:0]       rsp_removed_position,
   output logic [31:0]      rsp_color_out,
   output logic [8:0]       rsp_entry_count,
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   import mruch_pkg::*;

   localparam int PW = $clog2(MAX_ENTRIES);        // position width
   localparam int CW = $clog2(MAX_ENTRIES + 1);    // count width
   localparam int EW = (CW > 9) ? CW : 9;          // capacity compare width
   localparam int XW = CW + 8;                     // read index compare width

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_FIND,
      ST_APPLY
   } state_type;

   state_type state_ff, state_in;

   // item held while it works
   cmd_type               cmd_ff, cmd_in;
   logic [COLOR_BITS-1:0] key_ff, key_in;
   logic [7:0]            idx_ff, idx_in;

   // list state
   logic [CW-1:0]         held_ff, held_in;
   logic [8:0]            capacity_ff, capacity_in;

   // search results
   logic [MAX_ENTRIES-1:0] match_ff, match_in;
   logic [PW-1:0]          pos_ff, pos_in;
   logic                   hit_ff, hit_in;
   logic [COLOR_BITS-1:0]  rd_ff, rd_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   outcome_type outcome_ff, outcome_in;
   logic [7:0]  old_pos_ff, old_pos_in;
   logic [7:0]  rem_pos_ff, rem_pos_in;
   logic [31:0] color_ff, color_in;
   logic [8:0]  count_ff, count_in;

   // chain
   logic [COLOR_BITS-1:0]  cell_entry [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] cell_match;
   logic                   shift_en;
   logic [PW-1:0]          shift_limit;

   logic          out_free;
   logic          csr_write;
   logic [CW-1:0] eff_cap;
   logic [EW-1:0] cap_ext;

   // ------------------------------------------------------------------
   // cell chain: cell 0 takes the key, cell i takes cell i-1
   // ------------------------------------------------------------------
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic [COLOR_BITS-1:0] prev;
      if (i == 0) begin : g_head
         assign prev = key_ff;
      end else begin : g_body
         assign prev = cell_entry[i-1];
      end
      mruch_cell #(
         .COLOR_BITS (COLOR_BITS),
         .POS_BITS   (PW),
         .INDEX      (i)
      ) u_cell (
         .clock       (clock),
         .shift_en    (shift_en),
         .shift_limit (shift_limit),
         .key         (key_ff),
         .prev_entry  (prev),
         .entry       (cell_entry[i]),
         .match       (cell_match[i])
      );
   end

   // ------------------------------------------------------------------
   // register port
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_CAPACITY) ? 32'(capacity_ff) : 32'd0;

   // capacity clamped to 1..MAX_ENTRIES
   assign cap_ext = EW'(capacity_ff);
   always_comb begin
      if (capacity_ff == 9'd0) begin
         eff_cap = CW'(1);
      end else if (cap_ext > EW'(MAX_ENTRIES)) begin
         eff_cap = CW'(MAX_ENTRIES);
      end else begin
         eff_cap = CW'(capacity_ff);
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // ------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      idx_in       = idx_ff;
      held_in      = held_ff;
      capacity_in  = capacity_ff;
      match_in     = match_ff;
      pos_in       = pos_ff;
      hit_in       = hit_ff;
      rd_in        = rd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      outcome_in   = outcome_ff;
      old_pos_in   = old_pos_ff;
      rem_pos_in   = rem_pos_ff;
      color_in     = color_ff;
      count_in     = count_ff;
      shift_en     = 1'b0;
      shift_limit  = '0;

      if (csr_write && (csr_paddr[2] == REG_CAPACITY)) begin
         capacity_in = csr_pwdata[8:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = cmd_type'(req_cmd);
               key_in   = COLOR_BITS'(req_color_word);
               idx_in   = req_read_index;
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            // only held slots take part
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               match_in[i] = cell_match[i] && (CW'(i) < held_ff);
            end
            state_in = ST_FIND;
         end
         ST_FIND: begin
            // held words are unique, so at most one slot matches
            pos_in = '0;
            hit_in = |match_ff;
            rd_in  = '0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               if (match_ff[i]) begin
                  pos_in = pos_in | PW'(i);
               end
               if (XW'(i) == XW'(idx_ff)) begin
                  rd_in = rd_in | cell_entry[i];
               end
            end
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               outcome_in   = OUT_READ_RANGE;
               old_pos_in   = '0;
               rem_pos_in   = '0;
               color_in     = '0;
               unique case (cmd_ff)
                  CMD_ADD: begin
                     if (hit_ff && (pos_ff == '0)) begin
                        outcome_in = OUT_ALREADY_FRONT;
                     end else if (hit_ff) begin
                        shift_en    = 1'b1;
                        shift_limit = pos_ff;
                        outcome_in  = OUT_MOVED;
                        old_pos_in  = 8'(pos_ff);
                     end else if (held_ff >= eff_cap) begin
                        // full: oldest kept slot is overwritten
                        shift_en    = 1'b1;
                        shift_limit = PW'(eff_cap - CW'(1));
                        held_in     = eff_cap;
                        outcome_in  = OUT_ADDED_EVICT;
                        rem_pos_in  = 8'(eff_cap - CW'(1));
                     end else begin
                        shift_en    = 1'b1;
                        shift_limit = PW'(held_ff);
                        held_in     = held_ff + CW'(1);
                        outcome_in  = OUT_ADDED;
                     end
                  end
                  CMD_READ: begin
                     if (XW'(idx_ff) < XW'(held_ff)) begin
                        outcome_in = OUT_READ_OK;
                        color_in   = 32'(rd_ff);
                     end
                  end
                  CMD_CLEAR: begin
                     held_in    = '0;
                     outcome_in = OUT_CLEARED;
                  end
                  CMD_RESERVED: begin
                     outcome_in = OUT_READ_RANGE;
                  end
                  default: begin
                     outcome_in = OUT_READ_RANGE;
                  end
               endcase
               count_in = 9'(held_in);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         capacity_ff  <= CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff     <= cmd_in;
      key_ff     <= key_in;
      idx_ff     <= idx_in;
      match_ff   <= match_in;
      pos_ff     <= pos_in;
      hit_ff     <= hit_in;
      rd_ff      <= rd_in;
      outcome_ff <= outcome_in;
      old_pos_ff <= old_pos_in;
      rem_pos_ff <= rem_pos_in;
      color_ff   <= color_in;
      count_ff   <= count_in;
   end

   assign req_ready            = (state_ff == ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_outcome          = outcome_ff;
   assign rsp_old_position     = old_pos_ff;
   assign rsp_removed_position = rem_pos_ff;
   assign rsp_color_out        = color_ff;
   assign rsp_entry_count      = count_ff;

endmodule

`default_nettype wire

@@ rtl/mruch_cell.sv @@
// ----------------------------------------------------------------------------
// mruch_cell - one slot of the history chain
// Holds one color word, compares it with the search key and, when told,
// takes the word of its upper neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module mruch_cell #(
   parameter int COLOR_BITS = 32,
   parameter int POS_BITS   = 8,
   parameter int INDEX      = 0
) (
   input  wire logic                  clock,
   input  wire logic                  shift_en,
   input  wire logic [POS_BITS-1:0]   shift_limit,
   input  wire logic [COLOR_BITS-1:0] key,
   input  wire logic [COLOR_BITS-1:0] prev_entry,
   output logic      [COLOR_BITS-1:0] entry,
   output logic                       match
);

   logic [COLOR_BITS-1:0] entry_ff;
   logic [COLOR_BITS-1:0] entry_in;
   logic                  load;

   // slots 0..limit move down one place
   assign load = shift_en && (POS_BITS'(INDEX) <= shift_limit);

   always_comb begin
      entry_in = entry_ff;
      if (load) begin
         entry_in = prev_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign match = (entry_ff == key);

endmodule

`default_nettype wire

@@ verif/mruch_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mruch_checker - result checker for the MRU unique color history
// Watches the item, result and register ports, keeps its own copy of the
// color list and compares every result with the predicted one.
// ----------------------------------------------------------------------------

module mruch_checker #(
   parameter int MAX_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_color_word,
   input  logic [7:0]  req_read_index,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_outcome,
   input  logic [7:0]  rsp_old_position,
   input  logic [7:0]  rsp_removed_position,
   input  logic [31:0] rsp_color_out,
   input  logic [8:0]  rsp_entry_count,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          fail_count,
   output int          outstanding
);

   import mruch_pkg::*;

   typedef struct packed {
      outcome_type outcome;
      logic [7:0]  old_pos;
      logic [7:0]  rem_pos;
      logic [31:0] color;
      logic [8:0]  count;
   } list_result_type;

   logic [31:0]     colors [MAX_ENTRIES];
   int              held;
   logic [8:0]      capacity;
   list_result_type result_q [$];
   list_result_type want;
   int              mismatches;

   initial begin
      fail_count  = 0;
      outstanding = 0;
      mismatches  = 0;
      held        = 0;
      capacity    = CAPACITY_RESET;
   end

   // shift positions [0, n) down one place, word lands at the front
   function automatic void insert_front(input logic [31:0] word, input int n);
      int last;
      last = (n > MAX_ENTRIES - 1) ? MAX_ENTRIES - 1 : n;
      for (int i = last; i > 0; i--) colors[i] = colors[i - 1];
      colors[0] = word;
   endfunction

   function automatic list_result_type predict_item(input cmd_type cmd,
                                                    input logic [31:0] word,
                                                    input logic [7:0] idx);
      list_result_type r;
      int found;
      int cap;
      r = '0;
      r.outcome = OUT_READ_RANGE;
      case (cmd)
         CMD_ADD: begin
            found = held;
            for (int i = 0; i < held && found == held; i++)
               if (colors[i] == word) found = i;
            if (found == 0 && held > 0) begin
               r.outcome = OUT_ALREADY_FRONT;
            end else if (found < held) begin
               insert_front(word, found);
               r.outcome = OUT_MOVED;
               r.old_pos = found[7:0];
            end else begin
               cap = capacity;
               if (cap == 0) cap = 1;
               if (cap > MAX_ENTRIES) cap = MAX_ENTRIES;
               if (held >= cap) begin
                  // full, or capacity lowered under the held count
                  insert_front(word, cap - 1);
                  held      = cap;
                  r.outcome = OUT_ADDED_EVICT;
                  r.rem_pos = 8'(cap - 1);
               end else begin
                  insert_front(word, held);
                  held++;
                  r.outcome = OUT_ADDED;
               end
            end
         end
         CMD_READ: begin
            if (idx < held) begin
               r.outcome = OUT_READ_OK;
               r.color   = colors[idx];
            end
         end
         CMD_CLEAR: begin
            held      = 0;
            r.outcome = OUT_CLEARED;
         end
         default: ;
      endcase
      r.count = held[8:0];
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         held     = 0;
         capacity = CAPACITY_RESET;
         result_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr[2] == REG_CAPACITY)
            capacity = csr_pwdata[8:0];
         // results are matched before new items are queued
         if (rsp_valid && rsp_ready) begin
            if (result_q.size() == 0) begin
               $error("result with no item pending, outcome %0d", rsp_outcome);
               mismatches++;
            end else begin
               want = result_q.pop_front();
               if (rsp_outcome !== want.outcome) begin
                  $error("outcome: expected %0d, got %0d", want.outcome, rsp_outcome);
                  mismatches++;
               end
               if (rsp_old_position !== want.old_pos) begin
                  $error("old_position: expected %0d, got %0d",
                         want.old_pos, rsp_old_position);
                  mismatches++;
               end
               if (rsp_removed_position !== want.rem_pos) begin
                  $error("removed_position: expected %0d, got %0d",
                         want.rem_pos, rsp_removed_position);
                  mismatches++;
               end
               if (rsp_color_out !== want.color) begin
                  $error("color_out: expected %h, got %h", want.color, rsp_color_out);
                  mismatches++;
               end
               if (rsp_entry_count !== want.count) begin
                  $error("entry_count: expected %0d, got %0d",
                         want.count, rsp_entry_count);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready)
            result_q.push_back(predict_item(cmd_type'(req_cmd), req_color_word,
                                            req_read_index));
      end
      outstanding <= result_q.size();
      fail_count  <= mismatches;
   end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - regression bench for mru_unique_color_history_core
// Directed adds, moves, evictions, reads and clears, then random phases at
// several capacities with varying backpressure; a checker predicts results.
// ----------------------------------------------------------------------------

module tb;
   import mruch_pkg::*;

   // worst item stays well under this bound even at the heaviest stalls
   localparam int CYCLE_LIMIT = 500_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = CMD_ADD;
   logic [31:0] req_color_word = '0;
   logic [7:0]  req_read_index = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_outcome;
   logic [7:0]  rsp_old_position;
   logic [7:0]  rsp_removed_position;
   logic [31:0] rsp_color_out;
   logic [8:0]  rsp_entry_count;

   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          fail_count;
   int          outstanding;
   int          cycles = 0;

   // idle odds in percent, changed per phase
   int          send_idle_pct = 17;
   int          take_idle_pct = 66;

   // small set of colors reused so adds hit existing entries
   logic [31:0] palette [16];

   always #1 clock = ~clock;

   mru_unique_color_history_core u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_cmd              (req_cmd),
      .req_color_word       (req_color_word),
      .req_read_index       (req_read_index),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_outcome          (rsp_outcome),
      .rsp_old_position     (rsp_old_position),
      .rsp_removed_position (rsp_removed_position),
      .rsp_color_out        (rsp_color_out),
      .rsp_entry_count      (rsp_entry_count),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   mruch_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_cmd              (req_cmd),
      .req_color_word       (req_color_word),
      .req_read_index       (req_read_index),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_outcome          (rsp_outcome),
      .rsp_old_position     (rsp_old_position),
      .rsp_removed_position (rsp_removed_position),
      .rsp_color_out        (rsp_color_out),
      .rsp_entry_count      (rsp_entry_count),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_pready           (csr_pready),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .fail_count           (fail_count),
      .outstanding          (outstanding)
   );

   // result side stalls at random, redrawn every cycle
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= take_idle_pct);
   end

   // watchdog: a stuck handshake or a lost result ends here
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // One item. An optional gap drops valid first; with no gap valid stays
   // high and only the payload moves, so valid is never toggled in one step.
   task automatic send_item(input cmd_type cmd, input logic [31:0] word,
                            input logic [7:0] idx);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_color_word <= word;
      req_read_index <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // drop valid and wait until every queued result is back; the extra edge
   // lets the checker count an item accepted on the edge we came in on
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // capacity write while idle, random upper data bits
   task automatic write_capacity(input logic [8:0] value);
      logic [31:0] wdata;
      wdata      = $urandom;
      wdata[8:0] = value;
      drain();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {REG_CAPACITY, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Random items. Reserved code is rare noise; fresh words are new colors,
   // the rest come from the first pool_n palette entries to force hits.
   task automatic run_random(input int n, input int clear_pct, input int read_pct,
                             input int fresh_pct, input int pool_n);
      int          r;
      cmd_type     cmd;
      logic [31:0] word;
      logic [7:0]  idx;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(99);
         if (r < 2)
            cmd = CMD_RESERVED;
         else if (r < 2 + clear_pct)
            cmd = CMD_CLEAR;
         else if (r < 2 + clear_pct + read_pct)
            cmd = CMD_READ;
         else
            cmd = CMD_ADD;
         if ($urandom_range(99) < fresh_pct)
            word = $urandom;
         else
            word = palette[$urandom_range(pool_n - 1)];
         // half the reads near the front, half across the full index range
         if ($urandom_range(1) == 1)
            idx = 8'($urandom);
         else
            idx = 8'($urandom_range(7));
         send_item(cmd, word, idx);
      end
   endtask

   initial begin
      for (int i = 0; i < 16; i++) palette[i] = $urandom;
      palette[0] = '0;
      palette[1] = '1;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed, reset capacity 200 ----
      send_item(CMD_READ, 32'h0, 8'd0);             // read of empty list
      send_item(CMD_RESERVED, 32'hFFFF_FFFF, 8'hFF);// reserved code, no change
      send_item(CMD_ADD, 32'h0000_0000, 8'd0);      // added
      send_item(CMD_ADD, 32'h0000_0000, 8'd0);      // already at front
      send_item(CMD_ADD, 32'hFFFF_FFFF, 8'd0);      // added
      send_item(CMD_ADD, 32'hA5A5_A5A5, 8'd0);      // added
      send_item(CMD_ADD, 32'h0000_0000, 8'd0);      // moved up from 2
      send_item(CMD_READ, 32'h0, 8'd0);
      send_item(CMD_READ, 32'h0, 8'd2);
      send_item(CMD_READ, 32'h0, 8'd255);           // beyond held count
      send_item(CMD_CLEAR, 32'h0, 8'd0);
      send_item(CMD_READ, 32'h0, 8'd0);             // cleared list reads empty

      // capacity zero acts as one
      write_capacity(9'd0);
      send_item(CMD_ADD, 32'h1, 8'd0);
      send_item(CMD_ADD, 32'h2, 8'd0);              // evicts position 0
      send_item(CMD_ADD, 32'h2, 8'd0);
      send_item(CMD_READ, 32'h0, 8'd0);

      // capacity three, list kept from before
      write_capacity(9'd3);
      send_item(CMD_ADD, 32'h3, 8'd0);
      send_item(CMD_ADD, 32'h4, 8'd0);              // list now full
      send_item(CMD_ADD, 32'h5, 8'd0);              // evicts position 2
      send_item(CMD_ADD, 32'h3, 8'd0);              // moved from the tail

      // capacity lowered under three held entries: moves still see all
      // three, a new color trims the list down to one
      write_capacity(9'd1);
      send_item(CMD_ADD, 32'h4, 8'd0);
      send_item(CMD_ADD, 32'h9, 8'd0);
      send_item(CMD_READ, 32'h0, 8'd0);

      // ---- phase 1: sender idles little, receiver a lot ----
      // all-ones capacity clamps to the full 256; mostly new colors so the
      // list fills and evicts from position 255
      write_capacity(9'h1FF);
      run_random(320, 0, 8, 95, 16);

      // ---- phase 2: roles swapped ----
      // capacity 5 written with the list full: trim on first new color,
      // small pool keeps moves and front hits frequent
      send_idle_pct = 66;
      take_idle_pct = 17;
      write_capacity(9'd5);
      run_random(200, 3, 20, 30, 8);

      // ---- phase 3: no idling ----
      send_idle_pct = 0;
      take_idle_pct = 0;
      write_capacity(9'd1);
      run_random(70, 3, 20, 50, 4);
      write_capacity(9'd16);
      run_random(110, 3, 20, 40, 16);

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
